// File: src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Item kinds, character codes and the command and status types that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h2a;

  typedef struct packed {
    logic load;
    logic write_char;
    logic copy_init;
    logic copy_step;
    logic clear_init;
    logic clear_step;
    logic read_issue;
    logic read_capture;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       needs_scroll;
    logic       ptr_last;
  } dp_status_t;

endpackage

// File: src/tccw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console cell writer controller
// Sequences dispatch, character writes, scroll copies, clears and reads.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output logic                 done_o,
  output tccw_pkg::dp_cmd_t    cmd_o,
  input  tccw_pkg::dp_status_t status_i
);
  import tccw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WRITE,
    S_COPY,
    S_COPY_TAIL,
    S_CLEAR,
    S_READ,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   done_q,  done_d;

  assign busy   = (state_q != S_IDLE) && (state_q != S_DONE);
  assign done_o = done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DISPATCH: begin
        case (status_i.kind)
          KIND_WRITE: state_d = S_WRITE;
          KIND_CLEAR: begin
            cmd_o.clear_init = 1'b1;
            state_d          = S_CLEAR;
          end
          KIND_READ: begin
            cmd_o.read_issue = 1'b1;
            state_d          = S_READ;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_WRITE: begin
        cmd_o.write_char = 1'b1;
        if (status_i.needs_scroll) begin
          cmd_o.copy_init = 1'b1;
          state_d         = S_COPY;
        end else begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (status_i.ptr_last) begin
          state_d = S_COPY_TAIL;
        end
      end
      S_COPY_TAIL: state_d = S_DONE;
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.ptr_last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.read_capture = 1'b1;
        state_d            = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase
    done_d = (state_d == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

// File: src/tccw_datapath.sv
// ----------------------------------------------------------------------------
// Text console cell writer datapath
// Holds the cursor, the attribute, the item and result registers, the sweep
// pointer and the screen RAM with its port selection.
// ----------------------------------------------------------------------------
module tccw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tccw_pkg::dp_cmd_t    cmd_i,
  output tccw_pkg::dp_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [1:0]           kind_i,
  input  logic [7:0]           char_code_i,
  input  logic [4:0]           read_row_i,
  input  logic [6:0]           read_col_i,
  output logic [15:0]          cell_data_o,
  output logic [6:0]           cursor_col_o,
  output logic [4:0]           cursor_row_o,
  output logic                 scrolled_o
);
  import tccw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [AW-1:0] PTR_LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS);

  logic [7:0]    attr_q;
  logic [1:0]    kind_q;
  logic [7:0]    code_q;
  logic [4:0]    rrow_q;
  logic [6:0]    rcol_q;
  logic [CW-1:0] col_q,  col_d;
  logic [RW-1:0] row_q,  row_d;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_pend_q;
  logic [15:0]   res_data_q;
  logic          scrolled_q;

  logic          is_cr, is_lf, col_last, row_last, in_range;
  logic [AW-1:0] cur_addr, rd_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  assign is_cr    = (code_q == CHAR_CR);
  assign is_lf    = (code_q == CHAR_LF);
  assign col_last = (col_q == COL_LAST);
  assign row_last = (row_q == ROW_LAST);
  assign in_range = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);
  assign cur_addr = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign rd_addr  = in_range ? AW'(32'(rrow_q) * COLUMNS + 32'(rcol_q)) : '0;

  assign status_o.kind         = kind_q;
  assign status_o.needs_scroll = !is_cr && (is_lf || col_last) && row_last;
  assign status_o.ptr_last     = (ptr_q == PTR_LAST);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.clear_init) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.write_char) begin
      if (is_cr) begin
        col_d = '0;
      end else if (is_lf || col_last) begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {attr_q, code_q};
    ram_raddr = ptr_q;
    if (cmd_i.write_char && !is_cr && !is_lf) begin
      ram_we = 1'b1;
    end else if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_q;
      ram_wdata = {attr_q, CHAR_SPACE};
    end else if (wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = ram_rdata;
    end
    if (cmd_i.read_issue) begin
      ram_raddr = rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q     <= ATTR_RESET;
      col_q      <= '0;
      row_q      <= '0;
      wr_pend_q  <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      col_q     <= col_d;
      row_q     <= row_d;
      wr_pend_q <= cmd_i.copy_step;
      if (cmd_i.load) begin
        scrolled_q <= 1'b0;
      end else if (cmd_i.write_char) begin
        scrolled_q <= status_o.needs_scroll;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      code_q     <= char_code_i;
      rrow_q     <= read_row_i;
      rcol_q     <= read_col_i;
      res_data_q <= '0;
    end else if (cmd_i.read_capture) begin
      res_data_q <= in_range ? ram_rdata : '0;
    end
    if (cmd_i.clear_init) begin
      ptr_q <= '0;
    end else if (cmd_i.copy_init) begin
      ptr_q <= ROW_SPAN;
    end else if (cmd_i.clear_step || cmd_i.copy_step) begin
      ptr_q <= ptr_q + AW'(1);
    end
    wr_addr_q <= ptr_q - ROW_SPAN;
  end

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cell_data_o  = res_data_q;
  assign cursor_col_o = 7'(col_q);
  assign cursor_row_o = 5'(row_q);
  assign scrolled_o   = scrolled_q;

endmodule

// File: src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// Character-cell console with a ROWS by COLUMNS screen RAM of 16-bit cells.
//
// An item is accepted at a rising edge with start high and busy low. It is
// one of: write character (carriage return, line feed or any other byte
// stored with the attribute), clear screen, or read one cell.
// Each item gives exactly one result, shown for one cycle with done_o high;
// the receiver cannot stall it. busy is low in the cycle that shows done_o,
// so the next item may be accepted there.
// A scrolling write adds a row copy through the single RAM port pair, and a
// clear runs a fill sweep over every cell; an unused kind goes straight to
// its result.
// The attribute channel is always ready and may be written while idle.
// Reset homes the cursor and sets the attribute to 0x2a; the screen RAM is
// not cleared and holds no defined contents until a clear or a write.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        done_o,
  output logic [15:0] cell_data_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic        scrolled_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import tccw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .status_i(status)
  );

  tccw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .cell_data_o (cell_data_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Drives the console with a short table of directed items and then with
// random phases of lines, long text, clears and cell reads under several
// attribute settings. A predictor follows the cursor, the screen contents
// and scrolling, and each result transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import tccw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 296;
  localparam int SCROLL_BUDGET = 200;
  localparam int CLEAR_BUDGET = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [4:0] row;
    logic [6:0] col;
  } console_item_t;

  typedef struct packed {
    logic [15:0] data;
    logic [6:0]  ccol;
    logic [4:0]  crow;
    logic        scrolled;
  } console_result_t;

  typedef struct packed {
    console_item_t   item;
    logic            known;
    console_result_t res;
  } directed_row_t;

  typedef struct {
    int print_w;
    int cr_w;
    int lf_w;
    int read_w;
    int clear_w;
  } item_mix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  kind_i;
  logic [7:0]  char_code_i;
  logic [4:0]  read_row_i;
  logic [6:0]  read_col_i;
  logic        done_o;
  logic [15:0] cell_data_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic        scrolled_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  logic [15:0]     screen_model [CELLS];
  bit              written_model [CELLS];
  int              cur_col;
  int              cur_row;
  logic [7:0]      attr_model;
  console_result_t pending_results [$];
  bit              gaps_on;
  int              scrolls_left;
  int              clears_left;
  int              errors;
  int              cycle_count;
  int              items_sent;
  int              reads_sent;
  int              clears_seen;
  int              scrolls_seen;

  text_console_cell_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .done_o      (done_o),
    .cell_data_o (cell_data_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit scrolls_next(console_item_t it);
    return it.kind == KIND_WRITE && it.code != CHAR_CR && cur_row == ROWS - 1 &&
           (it.code == CHAR_LF || cur_col == COLUMNS - 1);
  endfunction

  function automatic console_result_t console_step(console_item_t it);
    console_result_t r;
    int pos;
    int i;
    r = '0;
    case (it.kind)
      KIND_WRITE: begin
        if (it.code == CHAR_CR) begin
          cur_col = 0;
        end else begin
          if (it.code == CHAR_LF) begin
            cur_col = COLUMNS;
          end else begin
            pos = cur_row * COLUMNS + cur_col;
            screen_model[pos] = {attr_model, it.code};
            written_model[pos] = 1'b1;
            cur_col++;
          end
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
          if (cur_row >= ROWS) begin
            for (i = 0; i < CELLS - COLUMNS; i++) begin
              screen_model[i] = screen_model[i + COLUMNS];
              written_model[i] = written_model[i + COLUMNS];
            end
            cur_row = ROWS - 1;
            cur_col = 0;
            r.scrolled = 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < CELLS; i++) begin
          screen_model[i] = {attr_model, CHAR_SPACE};
          written_model[i] = 1'b1;
        end
        cur_col = 0;
        cur_row = 0;
      end
      KIND_READ: begin
        if (it.row < ROWS && it.col < COLUMNS) r.data = screen_model[it.row * COLUMNS + it.col];
      end
      default: begin
      end
    endcase
    r.ccol = cur_col[6:0];
    r.crow = cur_row[4:0];
    return r;
  endfunction

  function automatic console_item_t random_item(item_mix_t m);
    console_item_t it;
    int pick;
    it.kind = KIND_WRITE;
    it.code = 8'($urandom_range(255));
    it.row = 5'($urandom_range(31));
    it.col = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < m.print_w) begin
      if (it.code == CHAR_CR || it.code == CHAR_LF) it.code = CHAR_SPACE;
    end else if (pick < m.print_w + m.cr_w) begin
      it.code = CHAR_CR;
    end else if (pick < m.print_w + m.cr_w + m.lf_w) begin
      it.code = CHAR_LF;
    end else if (pick < m.print_w + m.cr_w + m.lf_w + m.read_w) begin
      it.kind = KIND_READ;
      if ($urandom_range(9) < 7) begin
        it.row = 5'($urandom_range(ROWS - 1));
        it.col = 7'($urandom_range(COLUMNS - 1));
      end
      if (it.row < ROWS && it.col < COLUMNS && !written_model[it.row * COLUMNS + it.col])
        it.col = 7'(COLUMNS + $urandom_range(127 - COLUMNS));
    end else if (pick < m.print_w + m.cr_w + m.lf_w + m.read_w + m.clear_w) begin
      it.kind = clears_left > 0 ? KIND_CLEAR : KIND_UNUSED;
    end else begin
      it.kind = KIND_UNUSED;
    end
    if (scrolls_next(it) && scrolls_left == 0) it.code = CHAR_CR;
    return it;
  endfunction

  task automatic issue_item(console_item_t it);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(99) < 26) begin
      start <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < 26) @(negedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= it.kind;
    char_code_i <= it.code;
    read_row_i  <= it.row;
    read_col_i  <= it.col;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic run_item(console_item_t it, logic known, console_result_t typed);
    console_result_t r;
    issue_item(it);
    if (scrolls_next(it)) scrolls_left--;
    if (it.kind == KIND_CLEAR) begin
      clears_left--;
      clears_seen++;
    end
    if (it.kind == KIND_READ) reads_sent++;
    r = console_step(it);
    if (r.scrolled) scrolls_seen++;
    pending_results.push_back(known ? typed : r);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_attr(logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    attr_model = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 8'($urandom_range(255));
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    console_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual data %h col %0d row %0d",
                 $time, cell_data_o, cursor_col_o, cursor_row_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("cell_data", want.data, cell_data_o);
        compare_field("cursor_col", 16'(want.ccol), 16'(cursor_col_o));
        compare_field("cursor_row", 16'(want.crow), 16'(cursor_row_o));
        compare_field("scrolled", 16'(want.scrolled), 16'(scrolled_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    item_mix_t     mixes [PHASES];
    logic [7:0]    attr_plan [PHASES];
    directed_row_t dir_tbl [$];
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_WRITE;
    char_code_i = 8'h00;
    read_row_i  = 5'd0;
    read_col_i  = 7'd0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 8'h00;
    cur_col = 0;
    cur_row = 0;
    attr_model = ATTR_RESET;
    foreach (written_model[i]) written_model[i] = 1'b0;
    gaps_on = 1'b1;
    scrolls_left = SCROLL_BUDGET;
    clears_left = CLEAR_BUDGET;

    mixes[0] = '{print_w: 55, cr_w: 5, lf_w: 15, read_w: 22, clear_w: 0};
    mixes[1] = '{print_w: 78, cr_w: 0, lf_w: 1, read_w: 18, clear_w: 0};
    mixes[2] = '{print_w: 55, cr_w: 5, lf_w: 12, read_w: 25, clear_w: 0};
    mixes[3] = '{print_w: 78, cr_w: 0, lf_w: 1, read_w: 18, clear_w: 0};
    mixes[4] = '{print_w: 75, cr_w: 1, lf_w: 1, read_w: 20, clear_w: 1};
    mixes[5] = '{print_w: 30, cr_w: 5, lf_w: 5, read_w: 56, clear_w: 1};
    attr_plan = '{8'h00, 8'hff, 8'($urandom_range(255)), 8'h80, 8'h01,
                  8'($urandom_range(255))};

    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_UNUSED, 8'hff, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd0, 7'd80}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, 8'h41, 5'd0, 7'd0}, 1'b1, '{16'h0000, 7'd1, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{16'h2a41, 7'd1, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, CHAR_CR, 5'd0, 7'd0}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, 8'h00, 5'd31, 7'd127}, 1'b1, '{16'h0000, 7'd1, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, 8'hff, 5'd0, 7'd0}, 1'b1, '{16'h0000, 7'd2, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'hff, 5'd0, 7'd0}, 1'b1, '{16'h2a00, 7'd2, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd0, 7'd1}, 1'b1, '{16'h2aff, 7'd2, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, CHAR_LF, 5'd0, 7'd0}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd25, 7'd0}, 1'b1, '{16'h0000, 7'd0, 5'd1, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, 8'h55, 5'd21, 7'd85}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_WRITE, 8'haa, 5'd10, 7'd42}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_CLEAR, 8'h00, 5'd0, 7'd0}, 1'b1, '{16'h0000, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd24, 7'd79}, 1'b1, '{16'h2a20, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{16'h2a20, 7'd0, 5'd0, 1'b0}});
    dir_tbl.push_back('{'{KIND_WRITE, 8'h7e, 5'd0, 7'd0}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_WRITE, CHAR_CR, 5'd0, 7'd0}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_WRITE, 8'h80, 5'd0, 7'd0}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd0, 7'd0}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_UNUSED, 8'h00, 5'd0, 7'd0}, 1'b0, '0});
    dir_tbl.push_back('{'{KIND_READ, 8'h00, 5'd31, 7'd0}, 1'b0, '0});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) run_item(dir_tbl[i].item, dir_tbl[i].known, dir_tbl[i].res);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_attr(attr_plan[p]);
      gaps_on = (p != 2);
      repeat (ITEMS_PER_PHASE) run_item(random_item(mixes[p]), 1'b0, '0);
    end
    settle();

    $display("Covered %0d items: %0d reads, %0d clears and %0d scrolls,",
             items_sent, reads_sent, clears_seen, scrolls_seen);
    $display("under the reset attribute and %0d written attribute settings.", PHASES);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
